// ----- hdl/rbf_pkg.sv -----
// Package for the resonator bias filter with noise.
// Holds the sequencer types, register indexes, fixed-point widths and the saturation helper.
// No dependencies.
package rbf_pkg;

    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SAMPLE_W = 24;
    localparam int unsigned COEF_W = 32;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned PROD_W = 64;
    localparam int unsigned WIDE_W = 43;
    localparam int unsigned ACC_W = 37;

    localparam logic [CFG_IDX_W-1:0] REG_FB1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FB2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_IN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CARRIER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd6;

    localparam logic signed [PROD_W-1:0] HALF_Q29 = 64'sd268435456;
    localparam logic signed [PROD_W-1:0] HALF_Q22 = 64'sd2097152;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC
    } state_t;

    typedef enum logic [2:0] {
        OP_FB1,
        OP_FB2,
        OP_FF,
        OP_NOISE_IN,
        OP_NOISE_FB,
        OP_MOD,
        OP_SCALE
    } op_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        begin
            if (v > $signed({{(WIDE_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}}))
            begin
                r = {1'b0, {(DATA_W-1){1'b1}}};
            end
            else if (v < $signed({{(WIDE_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}}))
            begin
                r = {1'b1, {(DATA_W-1){1'b0}}};
            end
            else
            begin
                r = v[DATA_W-1:0];
            end
            return r;
        end
    endfunction

endpackage

// ----- hdl/rbf_if.sv -----
// Valid/ready channel interfaces for the sample input and the result output.
// Depend on nothing but the field widths of the block.
interface rbf_in_if;
    logic valid;
    logic ready;
    logic signed [23:0] bias_sample;
    logic signed [23:0] noise_sample;

    modport source(output valid, output bias_sample, output noise_sample, input ready);
    modport sink(input valid, input bias_sample, input noise_sample, output ready);
endinterface

interface rbf_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] sensor_output;

    modport source(output valid, output sensor_output, input ready);
    modport sink(input valid, input sensor_output, output ready);
endinterface

// ----- hdl/resonator_bias_filter_with_noise.sv -----
// Resonator bias filter with noise-modulated carrier output.
// Accepts an input only when idle and computes seven products on the single shared 32x32
// multiplier, each with a multiply and an accumulate step; it waits in the last step while
// a result is still pending. rst_n clears the sequencer, config registers and filter state.
// Depends on rbf_pkg and the channel interfaces in rbf_if.sv.
module resonator_bias_filter_with_noise (
    input  logic                            clk,
    input  logic                            rst_n,
    rbf_in_if.sink                          in_ch,
    rbf_out_if.source                       out_ch,
    input  logic                            cfg_we,
    input  logic [rbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbf_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rbf_pkg::state_t state_reg, state_next;
    rbf_pkg::op_t op_reg, op_next;

    logic signed [31:0] fb1_reg, fb2_reg, ff_reg, gin_reg, gfb_reg, scale_reg;
    logic signed [23:0] carrier_reg;

    logic signed [31:0] filter_out_last_reg, filter_out_prev_reg, noise_out_last_reg;
    logic signed [23:0] bias_last_reg, bias_prev_reg, noise_in_last_reg;

    logic signed [23:0] x_reg, w_reg;
    logic signed [63:0] prod_reg;
    logic signed [rbf_pkg::ACC_W-1:0] acc_reg;
    logic signed [31:0] fac_reg, p_reg, out_data_reg;
    logic out_valid_reg;

    logic out_free;
    logic signed [24:0] bias_diff, noise_sum;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] rnd29_full, rnd22_full;
    logic signed [34:0] term29;
    logic signed [41:0] term22;
    logic signed [rbf_pkg::ACC_W-1:0] sum29;
    logic signed [31:0] sum_sat, fac_val;
    logic signed [32:0] fac_sum;

    assign out_free = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == rbf_pkg::ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.sensor_output = out_data_reg;

    assign bias_diff = {x_reg[23], x_reg} - {bias_prev_reg[23], bias_prev_reg};
    assign noise_sum = {w_reg[23], w_reg} + {noise_in_last_reg[23], noise_in_last_reg};

    always_comb
    begin
        case (op_reg)
            rbf_pkg::OP_FB1:
            begin
                mul_a = fb1_reg;
                mul_b = filter_out_last_reg;
            end
            rbf_pkg::OP_FB2:
            begin
                mul_a = fb2_reg;
                mul_b = filter_out_prev_reg;
            end
            rbf_pkg::OP_FF:
            begin
                mul_a = ff_reg;
                mul_b = {{7{bias_diff[24]}}, bias_diff};
            end
            rbf_pkg::OP_NOISE_IN:
            begin
                mul_a = gin_reg;
                mul_b = {{7{noise_sum[24]}}, noise_sum};
            end
            rbf_pkg::OP_NOISE_FB:
            begin
                mul_a = gfb_reg;
                mul_b = noise_out_last_reg;
            end
            rbf_pkg::OP_MOD:
            begin
                mul_a = fac_reg;
                mul_b = filter_out_last_reg;
            end
            rbf_pkg::OP_SCALE:
            begin
                mul_a = scale_reg;
                mul_b = p_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd29_full = prod_reg + rbf_pkg::HALF_Q29;
    assign rnd22_full = prod_reg + rbf_pkg::HALF_Q22;
    assign term29 = rnd29_full[63:29];
    assign term22 = rnd22_full[63:22];
    assign sum29 = acc_reg + {{2{term29[34]}}, term29};
    assign sum_sat = rbf_pkg::sat32({{6{sum29[rbf_pkg::ACC_W-1]}}, sum29});
    assign fac_sum = {{9{carrier_reg[23]}}, carrier_reg} + {sum_sat[31], sum_sat};
    assign fac_val = rbf_pkg::sat32({{10{fac_sum[32]}}, fac_sum});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbf_pkg::ST_IDLE;
            op_reg <= rbf_pkg::OP_FB1;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        case (state_reg)
            rbf_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    state_next = rbf_pkg::ST_MUL;
                    op_next = rbf_pkg::OP_FB1;
                end
            end
            rbf_pkg::ST_MUL:
            begin
                state_next = rbf_pkg::ST_ACC;
            end
            rbf_pkg::ST_ACC:
            begin
                if (op_reg == rbf_pkg::OP_SCALE)
                begin
                    if (out_free)
                    begin
                        state_next = rbf_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = rbf_pkg::ST_MUL;
                    op_next = rbf_pkg::op_t'(op_reg + 3'd1);
                end
            end
            default:
            begin
                state_next = rbf_pkg::ST_IDLE;
                op_next = rbf_pkg::OP_FB1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb1_reg <= '0;
            fb2_reg <= '0;
            ff_reg <= '0;
            gin_reg <= '0;
            gfb_reg <= '0;
            carrier_reg <= '0;
            scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rbf_pkg::REG_FB1: fb1_reg <= cfg_data;
                rbf_pkg::REG_FB2: fb2_reg <= cfg_data;
                rbf_pkg::REG_FF: ff_reg <= cfg_data;
                rbf_pkg::REG_NOISE_IN: gin_reg <= cfg_data;
                rbf_pkg::REG_NOISE_FB: gfb_reg <= cfg_data;
                rbf_pkg::REG_CARRIER: carrier_reg <= cfg_data[23:0];
                rbf_pkg::REG_SCALE: scale_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_out_last_reg <= '0;
            filter_out_prev_reg <= '0;
            bias_last_reg <= '0;
            bias_prev_reg <= '0;
            noise_in_last_reg <= '0;
            noise_out_last_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == rbf_pkg::ST_ACC)
            begin
                case (op_reg)
                    rbf_pkg::OP_FF:
                    begin
                        filter_out_prev_reg <= filter_out_last_reg;
                        filter_out_last_reg <= sum_sat;
                        bias_prev_reg <= bias_last_reg;
                        bias_last_reg <= x_reg;
                    end
                    rbf_pkg::OP_NOISE_FB:
                    begin
                        noise_in_last_reg <= w_reg;
                        noise_out_last_reg <= sum_sat;
                    end
                    rbf_pkg::OP_SCALE:
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            x_reg <= in_ch.bias_sample;
            w_reg <= in_ch.noise_sample;
        end
        if (state_reg == rbf_pkg::ST_MUL)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (state_reg == rbf_pkg::ST_ACC)
        begin
            case (op_reg)
                rbf_pkg::OP_FB1: acc_reg <= {{2{term29[34]}}, term29};
                rbf_pkg::OP_FB2: acc_reg <= sum29;
                rbf_pkg::OP_NOISE_IN: acc_reg <= {{2{term29[34]}}, term29};
                rbf_pkg::OP_NOISE_FB: fac_reg <= fac_val;
                rbf_pkg::OP_MOD: p_reg <= rbf_pkg::sat32({term22[41], term22});
                rbf_pkg::OP_SCALE:
                begin
                    if (out_free)
                    begin
                        out_data_reg <= rbf_pkg::sat32({{8{term29[34]}}, term29});
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> state_reg == rbf_pkg::ST_MUL && op_reg == rbf_pkg::OP_FB1)
        else $error("Accepted transaction did not start the product sequence.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> $stable(out_data_reg))
        else $error("Pending result was overwritten.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbf_pkg::ST_ACC && op_reg == rbf_pkg::OP_SCALE
            && out_valid_reg && !out_ch.ready |=> state_reg == rbf_pkg::ST_ACC)
        else $error("Sequencer finished while the result register was occupied.");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rbf_pkg::ST_MUL |=> state_reg == rbf_pkg::ST_ACC && $stable(op_reg))
        else $error("Multiply cycle was not followed by its accumulate cycle.");

endmodule
